// ----- rtl/lwbc_pkg.sv -----
`timescale 1ns / 1ps
package lwbc_pkg;
  localparam int CAPACITY     = 16;
  localparam int SLOT_W       = 4;
  localparam int FILE_ID_BITS = 16;
  localparam int BLOCK_W      = 32;

  localparam logic [2:0] ACT_LOOKUP     = 3'd0;
  localparam logic [2:0] ACT_PROBE      = 3'd1;
  localparam logic [2:0] ACT_INSERT     = 3'd2;
  localparam logic [2:0] ACT_INVALIDATE = 3'd3;
  localparam logic [2:0] ACT_CLEAN      = 3'd4;
  localparam logic [2:0] ACT_DROP_RANGE = 3'd5;
  localparam logic [2:0] ACT_FLUSH_FILE = 3'd6;
  localparam logic [2:0] ACT_FLUSH_ALL  = 3'd7;

  localparam logic KIND_STATUS    = 1'b0;
  localparam logic KIND_WRITEBACK = 1'b1;

  typedef struct packed {
    logic [2:0]              action;
    logic [FILE_ID_BITS-1:0] file_id;
    logic [63:0]             byte_offset;
    logic [63:0]             range_length;
    logic [BLOCK_W-1:0]      block_index;
    logic                    dirty_in;
  } in_item_t;

  typedef struct packed {
    logic                    result_kind;
    logic                    hit;
    logic [SLOT_W-1:0]       slot;
    logic [FILE_ID_BITS-1:0] out_file_id;
    logic [BLOCK_W-1:0]      out_block;
    logic                    last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PROMOTE,
    OP_REMOVE,
    OP_CLEAN,
    OP_ALLOC
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [SLOT_W-1:0]       slot;
    logic [SLOT_W-1:0]       rank_ref;
    logic                    set_dirty;
    logic                    dirty;
    logic [FILE_ID_BITS-1:0] file;
    logic [BLOCK_W-1:0]      block;
    logic [63:0]             first;
    logic [63:0]             lastb;
  } cell_cmd_t;

  typedef struct packed {
    logic                    valid;
    logic                    dirty;
    logic [FILE_ID_BITS-1:0] file;
    logic [BLOCK_W-1:0]      block;
    logic [SLOT_W-1:0]       rank;
    logic                    key_match;
    logic                    file_match;
    logic                    range_match;
  } cell_stat_t;
endpackage

// ----- rtl/lwbc_cell.sv -----
`timescale 1ns / 1ps
module lwbc_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lwbc_pkg::SLOT_W-1:0] cell_idx,
  input  lwbc_pkg::cell_cmd_t       cmd,
  input  logic                      free_in,
  output logic                      free_out,
  output logic                      is_free,
  output lwbc_pkg::cell_stat_t      stat
);
  logic                                valid_r, dirty_r;
  logic [lwbc_pkg::FILE_ID_BITS-1:0]   file_r;
  logic [lwbc_pkg::BLOCK_W-1:0]        block_r;
  logic [lwbc_pkg::SLOT_W-1:0]         rank_r;
  logic                                mine;
  logic                                fmatch;

  assign mine   = (cmd.slot == cell_idx);
  assign fmatch = valid_r && (file_r == cmd.file);

  // lowest free slot: first invalid cell with no free cell below it
  assign is_free  = !valid_r && !free_in;
  assign free_out = free_in || !valid_r;

  always_comb begin
    stat.valid       = valid_r;
    stat.dirty       = dirty_r;
    stat.file        = file_r;
    stat.block       = block_r;
    stat.rank        = rank_r;
    stat.file_match  = fmatch;
    stat.key_match   = fmatch && (block_r == cmd.block);
    stat.range_match = fmatch && ({32'b0, block_r} >= cmd.first) &&
                       ({32'b0, block_r} <= cmd.lastb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      unique case (cmd.op)
        lwbc_pkg::OP_PROMOTE: begin
          if (mine) begin
            rank_r <= '0;
            if (cmd.set_dirty) dirty_r <= cmd.dirty;
          end else if (valid_r && rank_r < cmd.rank_ref) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        lwbc_pkg::OP_REMOVE: begin
          if (mine) begin
            valid_r <= 1'b0;
            dirty_r <= 1'b0;
            rank_r  <= '0;
          end else if (valid_r && rank_r > cmd.rank_ref) begin
            rank_r <= rank_r - 1'b1;
          end
        end
        lwbc_pkg::OP_CLEAN: begin
          if (mine) dirty_r <= 1'b0;
        end
        lwbc_pkg::OP_ALLOC: begin
          if (mine) begin
            valid_r <= 1'b1;
            dirty_r <= cmd.dirty;
            rank_r  <= '0;
          end else if (valid_r) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == lwbc_pkg::OP_ALLOC && mine) begin
      file_r  <= cmd.file;
      block_r <= cmd.block;
    end
  end
endmodule

// ----- rtl/lru_writeback_block_cache_tags.sv -----
`timescale 1ns / 1ps
// Tag, dirty and LRU controller for a 16-entry fully associative write-back
// block cache. One transaction at a time; an insert into a full cache first
// evicts the least recent entry, writing it back if dirty. Range drop and
// flushes walk the 16 cells one per cycle while no writeback is held up.
// Each writeback waits for the output register to free.
// Each slot is a cell holding its key, dirty mark and recency rank; the
// controller broadcasts one command per cycle to the cell row, and the
// lowest free slot ripples along the row. Results leave through one output
// register; every transaction ends with a status item that has last set.
module lru_writeback_block_cache_tags (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lwbc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lwbc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);
  localparam int CAP = lwbc_pkg::CAPACITY;
  localparam int SW  = lwbc_pkg::SLOT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BOUND, ST_LAST, ST_DISPATCH, ST_WB_EVICT, ST_EVICT,
    ST_ALLOC, ST_WB_ONE, ST_FIN_ONE, ST_WALK, ST_STATUS
  } state_t;

  state_t                st_r;
  logic [4:0]            bs_r;
  lwbc_pkg::in_item_t    req_r;
  logic [63:0]           first_r, endb_r, lastb_r;
  logic [SW-1:0]         slot_r, walk_r;
  logic                  hit_r;
  logic [SW:0]           occ_r;
  logic                  out_valid_r, out_valid_nxt;
  lwbc_pkg::out_item_t   out_r;

  lwbc_pkg::cell_cmd_t   cmd;
  lwbc_pkg::cell_stat_t  stat [CAP];
  logic [CAP:0]          free_chain;
  logic [CAP-1:0]        is_free, valid_vec;

  logic                  out_free, out_load, any_hit, victim_found;
  logic [SW-1:0]         hit_slot, victim_slot, free_slot;
  logic                  walk_cond, walk_wb;
  logic [63:0]           sum, endb_nxt;
  logic                  sum_c;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign free_chain[0] = 1'b0;
  genvar g;
  generate
    for (g = 0; g < CAP; g++) begin : g_cell
      lwbc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (SW'(g)),
        .cmd      (cmd),
        .free_in  (free_chain[g]),
        .free_out (free_chain[g+1]),
        .is_free  (is_free[g]),
        .stat     (stat[g])
      );
      assign valid_vec[g] = stat[g].valid;
    end
  endgenerate

  always_comb begin
    any_hit      = 1'b0;
    hit_slot     = '0;
    victim_found = 1'b0;
    victim_slot  = '0;
    free_slot    = '0;
    for (int i = 0; i < CAP; i++) begin
      if (stat[i].key_match) begin
        any_hit  = 1'b1;
        hit_slot = SW'(i);
      end
      if (stat[i].valid && stat[i].rank == SW'(CAP - 1)) begin
        victim_found = 1'b1;
        victim_slot  = SW'(i);
      end
      if (is_free[i]) free_slot = SW'(i);
    end
  end

  // saturating range end
  assign {sum_c, sum} = {1'b0, req_r.byte_offset} + {1'b0, req_r.range_length} - 65'd1;
  assign endb_nxt = (sum_c && req_r.range_length != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;

  always_comb begin
    walk_cond = stat[walk_r].valid &&
                ((req_r.action == lwbc_pkg::ACT_FLUSH_ALL) ||
                 (req_r.action == lwbc_pkg::ACT_FLUSH_FILE && stat[walk_r].file_match) ||
                 (req_r.action == lwbc_pkg::ACT_DROP_RANGE && stat[walk_r].range_match &&
                  req_r.range_length != 64'd0));
    walk_wb   = walk_cond && stat[walk_r].dirty &&
                (req_r.action != lwbc_pkg::ACT_DROP_RANGE);
  end

  // load the output register, else drop the item once it is taken
  always_comb begin
    out_load = out_free && ((st_r == ST_WB_EVICT) || (st_r == ST_WB_ONE) ||
                            (st_r == ST_STATUS) || (st_r == ST_WALK && walk_wb));
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_comb begin
    cmd.op        = lwbc_pkg::OP_NONE;
    cmd.slot      = slot_r;
    cmd.rank_ref  = stat[slot_r].rank;
    cmd.set_dirty = 1'b0;
    cmd.dirty     = req_r.dirty_in;
    cmd.file      = req_r.file_id;
    cmd.block     = (req_r.action == lwbc_pkg::ACT_INVALIDATE ||
                     req_r.action == lwbc_pkg::ACT_CLEAN) ?
                    req_r.block_index : first_r[31:0];
    cmd.first     = first_r;
    cmd.lastb     = lastb_r;
    unique case (st_r)
      ST_DISPATCH: begin
        if (any_hit && (req_r.action == lwbc_pkg::ACT_LOOKUP ||
                        req_r.action == lwbc_pkg::ACT_INSERT)) begin
          cmd.op        = lwbc_pkg::OP_PROMOTE;
          cmd.slot      = hit_slot;
          cmd.rank_ref  = stat[hit_slot].rank;
          cmd.set_dirty = (req_r.action == lwbc_pkg::ACT_INSERT);
        end
      end
      ST_EVICT: cmd.op = lwbc_pkg::OP_REMOVE;
      ST_ALLOC: begin
        cmd.op   = lwbc_pkg::OP_ALLOC;
        cmd.slot = free_slot;
      end
      ST_FIN_ONE: cmd.op = (req_r.action == lwbc_pkg::ACT_INVALIDATE) ?
                           lwbc_pkg::OP_REMOVE : lwbc_pkg::OP_CLEAN;
      ST_WALK: begin
        cmd.slot     = walk_r;
        cmd.rank_ref = stat[walk_r].rank;
        if (walk_cond && (!walk_wb || out_free)) cmd.op = lwbc_pkg::OP_REMOVE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      bs_r        <= 5'd12;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) bs_r <= cfg_data;
      out_valid_r <= out_valid_nxt;
      unique case (st_r)
        ST_IDLE: if (in_valid) begin
          req_r   <= in_data;
          first_r <= in_data.byte_offset >> bs_r;
          st_r    <= ST_BOUND;
        end
        ST_BOUND: begin
          endb_r <= endb_nxt;
          st_r   <= ST_LAST;
        end
        ST_LAST: begin
          lastb_r <= endb_r >> bs_r;
          st_r    <= ST_DISPATCH;
        end
        ST_DISPATCH: begin
          priority case (1'b1)
            (req_r.action == lwbc_pkg::ACT_LOOKUP || req_r.action == lwbc_pkg::ACT_PROBE ||
             ((req_r.action == lwbc_pkg::ACT_INSERT) && any_hit)): begin
              hit_r  <= any_hit;
              slot_r <= any_hit ? hit_slot : '0;
              st_r   <= ST_STATUS;
            end
            (req_r.action == lwbc_pkg::ACT_INSERT): begin
              if (occ_r >= (SW+1)'(CAP) && victim_found) begin
                slot_r <= victim_slot;
                st_r   <= stat[victim_slot].dirty ? ST_WB_EVICT : ST_EVICT;
              end else begin
                st_r <= ST_ALLOC;
              end
            end
            (req_r.action == lwbc_pkg::ACT_INVALIDATE ||
             req_r.action == lwbc_pkg::ACT_CLEAN): begin
              hit_r  <= any_hit;
              slot_r <= any_hit ? hit_slot : '0;
              if (!any_hit) st_r <= ST_STATUS;
              else st_r <= stat[hit_slot].dirty ? ST_WB_ONE : ST_FIN_ONE;
            end
            default: begin
              hit_r  <= 1'b0;
              slot_r <= '0;
              walk_r <= '0;
              st_r   <= ST_WALK;
            end
          endcase
        end
        ST_WB_EVICT, ST_WB_ONE: if (out_free) begin
          out_r.result_kind <= lwbc_pkg::KIND_WRITEBACK;
          out_r.hit         <= 1'b0;
          out_r.slot        <= slot_r;
          out_r.out_file_id <= stat[slot_r].file;
          out_r.out_block   <= stat[slot_r].block;
          out_r.last        <= 1'b0;
          st_r <= (st_r == ST_WB_EVICT) ? ST_EVICT : ST_FIN_ONE;
        end
        ST_EVICT: begin
          occ_r <= occ_r - 1'b1;
          st_r  <= ST_ALLOC;
        end
        ST_ALLOC: begin
          occ_r  <= occ_r + 1'b1;
          hit_r  <= 1'b0;
          slot_r <= free_slot;
          st_r   <= ST_STATUS;
        end
        ST_FIN_ONE: begin
          if (req_r.action == lwbc_pkg::ACT_INVALIDATE) occ_r <= occ_r - 1'b1;
          st_r <= ST_STATUS;
        end
        ST_WALK: if (!walk_wb || out_free) begin
          if (walk_cond) begin
            hit_r <= 1'b1;
            occ_r <= occ_r - 1'b1;
          end
          if (walk_wb) begin
            out_r.result_kind <= lwbc_pkg::KIND_WRITEBACK;
            out_r.hit         <= 1'b0;
            out_r.slot        <= walk_r;
            out_r.out_file_id <= stat[walk_r].file;
            out_r.out_block   <= stat[walk_r].block;
            out_r.last        <= 1'b0;
          end
          walk_r <= walk_r + 1'b1;
          if (walk_r == SW'(CAP - 1)) st_r <= ST_STATUS;
        end
        ST_STATUS: if (out_free) begin
          out_r.result_kind <= lwbc_pkg::KIND_STATUS;
          out_r.hit         <= hit_r;
          out_r.slot        <= slot_r;
          out_r.out_file_id <= '0;
          out_r.out_block   <= '0;
          out_r.last        <= 1'b1;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> ($countones(valid_vec) == int'(occ_r)))
    else $error("occupancy does not match valid cells");
  a_one_txn: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> (out_data.result_kind == lwbc_pkg::KIND_STATUS))
    else $error("last flag on a writeback item");
endmodule

// ----- test/lru_writeback_block_cache_tags_checker.sv -----
`timescale 1ns / 1ps
module lru_writeback_block_cache_tags_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lwbc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lwbc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [4:0]          cfg_data,
  output int                  pending,
  output int                  failures
);
  logic                              tag_valid [lwbc_pkg::CAPACITY];
  logic                              tag_dirty [lwbc_pkg::CAPACITY];
  logic [lwbc_pkg::FILE_ID_BITS-1:0] tag_file  [lwbc_pkg::CAPACITY];
  logic [lwbc_pkg::BLOCK_W-1:0]      tag_block [lwbc_pkg::CAPACITY];
  logic [lwbc_pkg::SLOT_W-1:0]       tag_rank  [lwbc_pkg::CAPACITY];
  int                                fill;
  logic [4:0]                        blk_shift;
  lwbc_pkg::out_item_t               expected_q [$];

  function automatic lwbc_pkg::out_item_t result_of(logic kind, logic hit, int slot,
                                          logic [lwbc_pkg::FILE_ID_BITS-1:0] f,
                                          logic [lwbc_pkg::BLOCK_W-1:0] b, logic last);
    lwbc_pkg::out_item_t r;
    r.result_kind = kind;
    r.hit         = hit;
    r.slot        = slot[lwbc_pkg::SLOT_W-1:0];
    r.out_file_id = f;
    r.out_block   = b;
    r.last        = last;
    return r;
  endfunction

  task automatic expect_item(lwbc_pkg::out_item_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  function automatic int find_key(logic [lwbc_pkg::FILE_ID_BITS-1:0] f,
                                  logic [lwbc_pkg::BLOCK_W-1:0] b);
    for (int i = 0; i < lwbc_pkg::CAPACITY; i++)
      if (tag_valid[i] && tag_file[i] == f && tag_block[i] == b) return i;
    return -1;
  endfunction

  task automatic make_recent(int s);
    logic [lwbc_pkg::SLOT_W-1:0] r;
    r = tag_rank[s];
    for (int i = 0; i < lwbc_pkg::CAPACITY; i++)
      if (tag_valid[i] && tag_rank[i] < r) tag_rank[i]++;
    tag_rank[s] = '0;
  endtask

  task automatic evict(int s);
    logic [lwbc_pkg::SLOT_W-1:0] r;
    r = tag_rank[s];
    tag_valid[s] = 1'b0;
    tag_dirty[s] = 1'b0;
    tag_rank[s]  = '0;
    for (int i = 0; i < lwbc_pkg::CAPACITY; i++)
      if (tag_valid[i] && tag_rank[i] > r) tag_rank[i]--;
    if (fill > 0) fill--;
  endtask

  task automatic push_writeback(int s);
    expect_item(result_of(lwbc_pkg::KIND_WRITEBACK, 1'b0, s, tag_file[s], tag_block[s],
                          1'b0));
  endtask

  task automatic predict_cache(lwbc_pkg::in_item_t it);
    logic [63:0]                  endb, first, lastb;
    logic [lwbc_pkg::BLOCK_W-1:0] blk;
    logic                         any;
    int                           s, victim;
    blk = lwbc_pkg::BLOCK_W'(it.byte_offset >> blk_shift);
    any = 1'b0;
    case (it.action)
      lwbc_pkg::ACT_LOOKUP, lwbc_pkg::ACT_PROBE: begin
        s = find_key(it.file_id, blk);
        if (s < 0) begin
          expect_item(result_of(lwbc_pkg::KIND_STATUS, 1'b0, 0, '0, '0, 1'b1));
        end else begin
          if (it.action == lwbc_pkg::ACT_LOOKUP) make_recent(s);
          expect_item(result_of(lwbc_pkg::KIND_STATUS, 1'b1, s, '0, '0, 1'b1));
        end
      end
      lwbc_pkg::ACT_INSERT: begin
        s = find_key(it.file_id, blk);
        if (s >= 0) begin
          tag_dirty[s] = it.dirty_in;
          make_recent(s);
          expect_item(result_of(lwbc_pkg::KIND_STATUS, 1'b1, s, '0, '0, 1'b1));
        end else begin
          if (fill >= lwbc_pkg::CAPACITY) begin
            victim = 0;
            for (int i = 0; i < lwbc_pkg::CAPACITY; i++)
              if (tag_valid[i] && tag_rank[i] >= tag_rank[victim]) victim = i;
            if (tag_dirty[victim]) push_writeback(victim);
            evict(victim);
          end
          s = 0;
          for (int i = lwbc_pkg::CAPACITY - 1; i >= 0; i--)
            if (!tag_valid[i]) s = i;
          for (int i = 0; i < lwbc_pkg::CAPACITY; i++)
            if (tag_valid[i]) tag_rank[i]++;
          tag_valid[s] = 1'b1;
          tag_dirty[s] = it.dirty_in;
          tag_file[s]  = it.file_id;
          tag_block[s] = blk;
          tag_rank[s]  = '0;
          fill++;
          expect_item(result_of(lwbc_pkg::KIND_STATUS, 1'b0, s, '0, '0, 1'b1));
        end
      end
      lwbc_pkg::ACT_INVALIDATE, lwbc_pkg::ACT_CLEAN: begin
        s = find_key(it.file_id, it.block_index);
        if (s < 0) begin
          expect_item(result_of(lwbc_pkg::KIND_STATUS, 1'b0, 0, '0, '0, 1'b1));
        end else begin
          if (tag_dirty[s]) push_writeback(s);
          if (it.action == lwbc_pkg::ACT_INVALIDATE) evict(s);
          else tag_dirty[s] = 1'b0;
          expect_item(result_of(lwbc_pkg::KIND_STATUS, 1'b1, s, '0, '0, 1'b1));
        end
      end
      lwbc_pkg::ACT_DROP_RANGE: begin
        if (it.range_length != 0) begin
          endb = it.byte_offset + it.range_length - 64'd1;
          // saturate a range that wraps past the top of the offset space
          if (endb < it.byte_offset) endb = '1;
          first = it.byte_offset >> blk_shift;
          lastb = endb >> blk_shift;
          for (int i = 0; i < lwbc_pkg::CAPACITY; i++)
            if (tag_valid[i] && tag_file[i] == it.file_id &&
                {32'd0, tag_block[i]} >= first && {32'd0, tag_block[i]} <= lastb) begin
              evict(i);
              any = 1'b1;
            end
        end
        expect_item(result_of(lwbc_pkg::KIND_STATUS, any, 0, '0, '0, 1'b1));
      end
      default: begin
        for (int i = 0; i < lwbc_pkg::CAPACITY; i++)
          if (tag_valid[i] && (it.action == lwbc_pkg::ACT_FLUSH_ALL ||
                               tag_file[i] == it.file_id)) begin
            if (tag_dirty[i]) push_writeback(i);
            evict(i);
            any = 1'b1;
          end
        expect_item(result_of(lwbc_pkg::KIND_STATUS, any, 0, '0, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    lwbc_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < lwbc_pkg::CAPACITY; i++) begin
        tag_valid[i] = 1'b0;
        tag_dirty[i] = 1'b0;
        tag_file[i]  = '0;
        tag_block[i] = '0;
        tag_rank[i]  = '0;
      end
      fill      = 0;
      blk_shift = 5'd12;
      expected_q.delete();
      pending  = 0;
      failures = 0;
    end else begin
      // results leave before a new transaction can add to the queue
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          failures++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.result_kind !== want.result_kind || out_data.hit !== want.hit ||
              out_data.slot !== want.slot || out_data.out_file_id !== want.out_file_id ||
              out_data.out_block !== want.out_block || out_data.last !== want.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            failures++;
          end
        end
      end
      if (cfg_valid && cfg_ready) blk_shift = cfg_data;
      if (in_valid && in_ready) predict_cache(in_data);
      pending = expected_q.size();
    end
  end
endmodule

// ----- test/lru_writeback_block_cache_tags_tb.sv -----
`timescale 1ns / 1ps
module lru_writeback_block_cache_tags_tb;
  logic                clk;
  logic                rst_n;
  logic                in_valid, in_ready;
  lwbc_pkg::in_item_t  in_data;
  logic                out_valid, out_ready;
  lwbc_pkg::out_item_t out_data;
  logic                cfg_valid, cfg_ready;
  logic [4:0]          cfg_data;
  int                  pending, failures;
  int                  burst_left;
  int                  cyc;
  logic [4:0]          cur_shift;
  logic [4:0]          shifts [4];
  logic [15:0]         files [4];

  lru_writeback_block_cache_tags uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  lru_writeback_block_cache_tags_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .pending(pending), .failures(failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: mode rotates between no stall, random and periodic
  always @(posedge clk) begin
    if (!rst_n) begin
      cyc       <= 0;
      out_ready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      case ((cyc / 150) % 3)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ((cyc % 7) < 3);
      endcase
    end
  end

  function automatic lwbc_pkg::in_item_t req(logic [2:0] a, logic [15:0] f, logic [63:0] off,
                                             logic [63:0] len, logic [31:0] bidx, logic d);
    lwbc_pkg::in_item_t it;
    it.action       = a;
    it.file_id      = f;
    it.byte_offset  = off;
    it.range_length = len;
    it.block_index  = bidx;
    it.dirty_in     = d;
    return it;
  endfunction

  function automatic lwbc_pkg::in_item_t random_req();
    logic [63:0] lowmask, off;
    logic [31:0] blk;
    logic [15:0] f;
    logic [2:0]  a;
    int          w;
    w = $urandom_range(0, 99);
    if (w < 30)      a = lwbc_pkg::ACT_INSERT;
    else if (w < 45) a = lwbc_pkg::ACT_LOOKUP;
    else if (w < 55) a = lwbc_pkg::ACT_PROBE;
    else if (w < 66) a = lwbc_pkg::ACT_INVALIDATE;
    else if (w < 77) a = lwbc_pkg::ACT_CLEAN;
    else if (w < 88) a = lwbc_pkg::ACT_DROP_RANGE;
    else if (w < 96) a = lwbc_pkg::ACT_FLUSH_FILE;
    else             a = lwbc_pkg::ACT_FLUSH_ALL;
    f = ($urandom_range(0, 9) == 0) ? 16'($urandom) : files[$urandom_range(0, 3)];
    blk = $urandom_range(0, 23);
    lowmask = (64'd1 << cur_shift) - 64'd1;
    off = (64'(blk) << cur_shift) | ({$urandom, $urandom} & lowmask);
    if ($urandom_range(0, 9) == 0) off = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return req(a, f, off, {$urandom, $urandom},
                          ($urandom_range(0, 4) == 0) ? $urandom : blk, 1'($urandom));
      1:       return req(a, f, off, '1, blk, 1'($urandom));
      2:       return req(a, f, off, 64'd0, blk, 1'($urandom));
      default: return req(a, f, off, 64'($urandom_range(1, 4)) << cur_shift, blk,
                          1'($urandom));
    endcase
  endfunction

  task automatic send(lwbc_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // hold off until all results are back and the block has finished its walk
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_shift(logic [4:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_shift = v;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    burst_left = 0;
    cur_shift = 5'd12;
    shifts[0] = 5'd0;  shifts[1] = 5'd30; shifts[2] = 5'd12; shifts[3] = 5'd5;
    files[0] = 16'h0000; files[1] = 16'hFFFF; files[2] = 16'h1234; files[3] = 16'h00A5;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 4; p++) begin
      write_shift(shifts[p]);
      if (p == 0) begin
        // block size of one byte: offset equals block number
        send(req(lwbc_pkg::ACT_INSERT, 16'h0000, 64'd0, 64'd0, 32'd0, 1'b1));
        send(req(lwbc_pkg::ACT_INSERT, 16'hFFFF, '1, '1, '1, 1'b0));
        send(req(lwbc_pkg::ACT_LOOKUP, 16'hFFFF, '1, 64'd0, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_PROBE, 16'h0000, 64'd0, 64'd0, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_LOOKUP, 16'h0001, 64'd5, 64'd0, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_INSERT, 16'h0000, 64'd0, 64'd0, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_INSERT, 16'h0000, 64'd0, 64'd0, 32'd0, 1'b1));
        send(req(lwbc_pkg::ACT_CLEAN, 16'h0000, 64'd0, 64'd0, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_CLEAN, 16'h0000, 64'd0, 64'd0, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_INVALIDATE, 16'hFFFF, 64'd0, 64'd0, '1, 1'b0));
        send(req(lwbc_pkg::ACT_INVALIDATE, 16'hFFFF, 64'd0, 64'd0, '1, 1'b0));
        // overfill so the least recent entry is evicted
        for (int i = 0; i < 17; i++)
          send(req(lwbc_pkg::ACT_INSERT, 16'h1234, 64'(i), 64'd0, 32'd0, i[0]));
        send(req(lwbc_pkg::ACT_DROP_RANGE, 16'h1234, 64'd3, 64'd0, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_DROP_RANGE, 16'h1234, 64'd3, 64'd2, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_DROP_RANGE, 16'h1234, 64'd12, '1, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_FLUSH_FILE, 16'h1234, 64'd0, 64'd0, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_INSERT, 16'h00A5, 64'd7, 64'd0, 32'd0, 1'b1));
        send(req(lwbc_pkg::ACT_FLUSH_ALL, 16'h0000, 64'd0, 64'd0, 32'd0, 1'b0));
        send(req(lwbc_pkg::ACT_FLUSH_ALL, 16'h0000, 64'd0, 64'd0, 32'd0, 1'b0));
      end
      for (int n = 0; n < 19; n++) begin
        if ($urandom_range(0, 19) == 0) drain();
        send(random_req());
      end
      drain();
    end
    if (failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/lwbc_pkg.sv
rtl/lwbc_cell.sv
rtl/lru_writeback_block_cache_tags.sv
test/lru_writeback_block_cache_tags_checker.sv
test/lru_writeback_block_cache_tags_tb.sv
